@@ sv/psc_pkg.sv @@
// Shared types and constants for the preset selector controller.
// Depends on nothing; every other file imports it.
package psc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_HOLD_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BROWSE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_TIME     = 2'd2;

    localparam logic [CFG_W-1:0] SAVE_HOLD_TIME_RST = 16'd1000;
    localparam logic [CFG_W-1:0] BROWSE_TIMEOUT_RST = 16'd3000;
    localparam logic [CFG_W-1:0] BLINK_TIME_RST     = 16'd300;

    // Command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_SAVE = 2'd2;

    localparam logic [3:0] CODE_BLANK = 4'd10;

    typedef struct packed {
        logic [7:0]  knob_value;
        logic        knob_moved;
        logic        button_toggled;
        logic        button_down;
        logic [31:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] command_slot;
        logic       knob_restore;
        logic [7:0] restore_value;
        logic       display_update;
        logic [3:0] digit_hundreds;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
    } result_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

endpackage

@@ sv/psc_digits.sv @@
// Splits an 8-bit slot number into three decimal digit codes, leading blanks.
// Depends on psc_pkg.
module psc_digits
    import psc_pkg::*;
(
    input  logic [7:0] value,
    output digits_t    digits
);

    logic [15:0] prod100;
    logic [15:0] prod10;
    logic [3:0]  q100;
    logic [4:0]  q10;
    logic [7:0]  tens_rem;
    logic [7:0]  ones_rem;

    // Reciprocal multiply: exact for every 8-bit value
    assign prod100  = 16'(value) * 16'd41;
    assign prod10   = 16'(value) * 16'd205;
    assign q100     = prod100[15:12];
    assign q10      = prod10[15:11];
    assign tens_rem = 8'(q10) - 8'(q100) * 8'd10;
    assign ones_rem = value - 8'(q10) * 8'd10;

    always_comb
    begin
        digits.hundreds = (value >= 8'd100) ? q100 : CODE_BLANK;
        digits.tens     = (value >= 8'd10) ? tens_rem[3:0] : CODE_BLANK;
        digits.ones     = ones_rem[3:0];
    end

endmodule

@@ sv/preset_selector_controller_unit.sv @@
// Top level of the preset selector controller: poll register, decision logic,
// state registers and result register. Depends on psc_pkg and psc_digits.
//
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------
// poll     | in        | poll_valid / poll_ready    | poll   (poll_t)
// result   | out       | result_valid / result_ready| result (result_t)
// config   | in        | cfg_write, no wait         | cfg_index, cfg_data
//
// One result per poll, registered twice on its way: first in the poll
// register, then in the result register. A poll can be taken every cycle while poll_ready is high.
// All decisions of a poll are made combinationally between the two registers.
// Reset clears the slot, browse, blink and press state and loads the
// register defaults. A stalled result holds the poll register; poll_ready
// drops only when both are full.
module preset_selector_controller_unit
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 poll_valid,
    output logic                 poll_ready,
    input  poll_t                poll,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] save_hold_time_reg;
    logic [CFG_W-1:0] browse_timeout_reg;
    logic [CFG_W-1:0] blink_time_reg;

    logic        in_valid_reg;
    poll_t       in_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic [7:0]  active_slot_reg, active_slot_next;
    logic        browse_on_reg, browse_on_next;
    logic [31:0] browse_start_reg, browse_start_next;
    logic        blink_on_reg, blink_on_next;
    logic [31:0] blink_start_reg, blink_start_next;
    logic [31:0] press_start_reg, press_start_next;

    logic        advance;
    logic        show;
    logic        show_blank;
    logic [7:0]  show_value;
    logic        done;
    logic [31:0] held;
    digits_t     digits;

    assign advance      = !out_valid_reg || result_ready;
    assign poll_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            save_hold_time_reg <= SAVE_HOLD_TIME_RST;
            browse_timeout_reg <= BROWSE_TIMEOUT_RST;
            blink_time_reg     <= BLINK_TIME_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAVE_HOLD_TIME: save_hold_time_reg <= cfg_data;
                REG_BROWSE_TIMEOUT: browse_timeout_reg <= cfg_data;
                REG_BLINK_TIME:     blink_time_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    psc_digits u_digits (
        .value  (show_value),
        .digits (digits)
    );

    always_comb
    begin
        active_slot_next  = active_slot_reg;
        browse_on_next    = browse_on_reg;
        browse_start_next = browse_start_reg;
        blink_on_next     = blink_on_reg;
        blink_start_next  = blink_start_reg;
        press_start_next  = press_start_reg;
        out_next          = '0;
        show              = 1'b0;
        show_blank        = 1'b0;
        show_value        = in_reg.knob_value;
        done              = 1'b0;
        held              = in_reg.now_ms - press_start_reg;

        if (in_reg.knob_moved)
        begin
            blink_on_next    = 1'b0;
            blink_start_next = '0;
            if (in_reg.knob_value == active_slot_reg)
            begin
                browse_on_next    = 1'b0;
                browse_start_next = '0;
            end
            else
            begin
                browse_on_next    = 1'b1;
                browse_start_next = in_reg.now_ms;
            end
            show = 1'b1;
        end

        if (in_reg.button_toggled)
        begin
            if (in_reg.button_down)
            begin
                // press ends a blink and the poll
                if (blink_on_next)
                begin
                    blink_on_next    = 1'b0;
                    blink_start_next = '0;
                    show             = 1'b1;
                end
                press_start_next = in_reg.now_ms;
                done             = 1'b1;
            end
            else
            begin
                press_start_next      = '0;
                out_next.command      = (held >= 32'(save_hold_time_reg)) ? CMD_SAVE
                                                                          : CMD_LOAD;
                out_next.command_slot = in_reg.knob_value;
                active_slot_next      = in_reg.knob_value;
                browse_on_next        = 1'b0;
                browse_start_next     = '0;
                blink_on_next         = 1'b0;
                blink_start_next      = '0;
                show                  = 1'b1;
            end
        end

        if (!done)
        begin
            if (blink_on_next)
            begin
                if ((in_reg.now_ms - blink_start_next) >= 32'(blink_time_reg))
                begin
                    blink_on_next          = 1'b0;
                    blink_start_next       = '0;
                    browse_on_next         = 1'b0;
                    browse_start_next      = '0;
                    out_next.knob_restore  = 1'b1;
                    out_next.restore_value = active_slot_next;
                    show                   = 1'b1;
                    show_value             = active_slot_next;
                end
            end
            else if (browse_on_next && !in_reg.button_down &&
                     (in_reg.now_ms - browse_start_next) >= 32'(browse_timeout_reg))
            begin
                blink_on_next    = 1'b1;
                blink_start_next = in_reg.now_ms;
                show             = 1'b1;
                show_blank       = 1'b1;
            end
        end

        out_next.display_update = show;
        if (show_blank)
        begin
            out_next.digit_hundreds = CODE_BLANK;
            out_next.digit_tens     = CODE_BLANK;
            out_next.digit_ones     = CODE_BLANK;
        end
        else if (show)
        begin
            out_next.digit_hundreds = digits.hundreds;
            out_next.digit_tens     = digits.tens;
            out_next.digit_ones     = digits.ones;
        end
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_slot_reg  <= '0;
            browse_on_reg    <= 1'b0;
            browse_start_reg <= '0;
            blink_on_reg     <= 1'b0;
            blink_start_reg  <= '0;
            press_start_reg  <= '0;
        end
        else
        begin
            if (poll_ready)
            begin
                in_valid_reg <= poll_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // commit the state as the poll moves into the result register
            if (advance && in_valid_reg)
            begin
                active_slot_reg  <= active_slot_next;
                browse_on_reg    <= browse_on_next;
                browse_start_reg <= browse_start_next;
                blink_on_reg     <= blink_on_next;
                blink_start_reg  <= blink_start_next;
                press_start_reg  <= press_start_next;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (poll_ready && poll_valid)
        begin
            in_reg <= poll;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    a_restore_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.knob_restore) |-> (result.command == CMD_NONE))
        else $error("restore and command in the same result");

    a_quiet_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.display_update) |->
        (result.digit_hundreds == 4'd0 && result.digit_tens == 4'd0 &&
         result.digit_ones == 4'd0))
        else $error("digits set without display update");

    a_restore_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.knob_restore) |-> (result.restore_value == 8'd0))
        else $error("restore value without restore");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_valid && poll_ready && in_valid_reg) |-> advance)
        else $error("poll transfer while poll register is stuck");

    // browsing stays on while the blink runs
    a_blink_from_browse: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blink_on_reg) |-> browse_on_reg)
        else $error("blink started without browsing");

endmodule

@@ test/tb_top.sv @@
// Testbench for preset_selector_controller_unit: random and directed polls, in-order
// checking against a behavioral predictor. Depends on psc_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top
    import psc_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 poll_valid = 1'b0;
    logic                 poll_ready;
    poll_t                poll = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    preset_selector_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Predicted controller state and register copies
    logic [7:0]       cur_slot = '0;
    logic             browsing = 1'b0;
    logic [31:0]      browse_t0 = '0;
    logic             blanking = 1'b0;
    logic [31:0]      blank_t0 = '0;
    logic [31:0]      press_t0 = '0;
    logic [CFG_W-1:0] hold_ms = SAVE_HOLD_TIME_RST;
    logic [CFG_W-1:0] timeout_ms = BROWSE_TIMEOUT_RST;
    logic [CFG_W-1:0] blank_ms = BLINK_TIME_RST;

    poll_t   pending_polls[$];
    result_t expected_results[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          queued_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] gen_now = '0;
    logic [7:0]  gen_slot = '0;

    function automatic digits_t slot_digits(logic [7:0] v);
        digits_t d;
        d.hundreds = (v >= 8'd100) ? 4'(v / 8'd100) : CODE_BLANK;
        d.tens     = (v >= 8'd10) ? 4'((v / 8'd10) % 8'd10) : CODE_BLANK;
        d.ones     = 4'(v % 8'd10);
        return d;
    endfunction

    // Advance the predicted state by one poll and return the result it causes
    function automatic result_t predict_result(poll_t p);
        result_t     r;
        logic [31:0] elapsed;
        r = '0;
        if (p.knob_moved)
        begin
            blanking = 1'b0;
            blank_t0 = '0;
            if (p.knob_value == cur_slot)
            begin
                browsing = 1'b0;
                browse_t0 = '0;
            end
            else
            begin
                browsing = 1'b1;
                browse_t0 = p.now_ms;
            end
            r.display_update = 1'b1;
            {r.digit_hundreds, r.digit_tens, r.digit_ones} = slot_digits(p.knob_value);
        end
        if (p.button_toggled && p.button_down)
        begin
            if (blanking)
            begin
                blanking = 1'b0;
                blank_t0 = '0;
                r.display_update = 1'b1;
                {r.digit_hundreds, r.digit_tens, r.digit_ones} = slot_digits(p.knob_value);
            end
            press_t0 = p.now_ms;
            return r;
        end
        if (p.button_toggled)
        begin
            elapsed = p.now_ms - press_t0;
            press_t0 = '0;
            r.command = (elapsed >= 32'(hold_ms)) ? CMD_SAVE : CMD_LOAD;
            r.command_slot = p.knob_value;
            cur_slot = p.knob_value;
            browsing = 1'b0;
            browse_t0 = '0;
            blanking = 1'b0;
            blank_t0 = '0;
            r.display_update = 1'b1;
            {r.digit_hundreds, r.digit_tens, r.digit_ones} = slot_digits(p.knob_value);
        end
        if (blanking)
        begin
            elapsed = p.now_ms - blank_t0;
            if (elapsed >= 32'(blank_ms))
            begin
                blanking = 1'b0;
                blank_t0 = '0;
                browsing = 1'b0;
                browse_t0 = '0;
                r.knob_restore = 1'b1;
                r.restore_value = cur_slot;
                r.display_update = 1'b1;
                {r.digit_hundreds, r.digit_tens, r.digit_ones} = slot_digits(cur_slot);
            end
        end
        else
        begin
            elapsed = p.now_ms - browse_t0;
            if (browsing && !p.button_down && elapsed >= 32'(timeout_ms))
            begin
                blanking = 1'b1;
                blank_t0 = p.now_ms;
                r.display_update = 1'b1;
                {r.digit_hundreds, r.digit_tens, r.digit_ones} =
                    {CODE_BLANK, CODE_BLANK, CODE_BLANK};
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic check_result(input result_t got);
        result_t exp;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no poll outstanding");
            return;
        end
        exp = expected_results.pop_front();
        if (got.command !== exp.command)
            report_mismatch($sformatf("command got %0d expected %0d",
                                      got.command, exp.command));
        if (got.command_slot !== exp.command_slot)
            report_mismatch($sformatf("command_slot got %0d expected %0d",
                                      got.command_slot, exp.command_slot));
        if (got.knob_restore !== exp.knob_restore)
            report_mismatch($sformatf("knob_restore got %0d expected %0d",
                                      got.knob_restore, exp.knob_restore));
        if (got.restore_value !== exp.restore_value)
            report_mismatch($sformatf("restore_value got %0d expected %0d",
                                      got.restore_value, exp.restore_value));
        if (got.display_update !== exp.display_update)
            report_mismatch($sformatf("display_update got %0d expected %0d",
                                      got.display_update, exp.display_update));
        if (got.digit_hundreds !== exp.digit_hundreds)
            report_mismatch($sformatf("digit_hundreds got %0d expected %0d",
                                      got.digit_hundreds, exp.digit_hundreds));
        if (got.digit_tens !== exp.digit_tens)
            report_mismatch($sformatf("digit_tens got %0d expected %0d",
                                      got.digit_tens, exp.digit_tens));
        if (got.digit_ones !== exp.digit_ones)
            report_mismatch($sformatf("digit_ones got %0d expected %0d",
                                      got.digit_ones, exp.digit_ones));
    endtask

    // Poll driver: predict on each transfer, then present the next pending poll
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid <= 1'b0;
            poll <= '0;
        end
        else
        begin
            if (poll_valid && poll_ready)
                expected_results.push_back(predict_result(poll));
            if (!poll_valid || poll_ready)
            begin
                if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    poll_valid <= 1'b1;
                    poll <= pending_polls.pop_front();
                end
                else
                    poll_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_poll(input logic [7:0] knob, input logic vchg, input logic schg,
                             input logic down, input logic [31:0] t_ms);
        poll_t p;
        p.knob_value = knob;
        p.knob_moved = vchg;
        p.button_toggled = schg;
        p.button_down = down;
        p.now_ms = t_ms;
        pending_polls.push_back(p);
        queued_count++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || poll_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SAVE_HOLD_TIME: hold_ms = val;
            REG_BROWSE_TIMEOUT: timeout_ms = val;
            REG_BLINK_TIME:     blank_ms = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] timeout,
                              input logic [CFG_W-1:0] blink);
        write_reg(REG_SAVE_HOLD_TIME, hold);
        write_reg(REG_BROWSE_TIMEOUT, timeout);
        write_reg(REG_BLINK_TIME, blink);
    endtask

    // Turn the knob, then let time run toward the timeout and the blink expiry
    task automatic browse_run();
        logic [7:0]  k;
        logic [31:0] t0;
        logic [31:0] stride;
        k = ($urandom_range(4) == 0) ? gen_slot : 8'($urandom_range(255));
        gen_now += $urandom_range(20);
        t0 = gen_now;
        push_poll(k, 1'b1, 1'b0, 1'b0, t0);
        if ($urandom_range(2) == 0)
        begin
            // hit both thresholds one tick early and exactly
            if (timeout_ms != 0)
                push_poll(k, 1'b0, 1'b0, 1'b0, t0 + 32'(timeout_ms) - 1);
            push_poll(k, 1'b0, 1'b0, 1'b0, t0 + 32'(timeout_ms));
            if (blank_ms != 0)
                push_poll(k, 1'b0, 1'b0, 1'b0, t0 + 32'(timeout_ms) + 32'(blank_ms) - 1);
            gen_now = t0 + 32'(timeout_ms) + 32'(blank_ms);
            push_poll(k, 1'b0, 1'b0, 1'b0, gen_now);
        end
        else
        begin
            stride = (32'(timeout_ms) + 32'(blank_ms)) / 3 + 1;
            repeat ($urandom_range(8, 1))
            begin
                gen_now += $urandom_range(stride);
                push_poll(k, 1'b0, 1'b0, 1'b0, gen_now);
            end
        end
    endtask

    // Press, hold for a time around the save threshold, release
    task automatic press_run();
        logic [7:0]  k;
        logic [31:0] t0;
        logic [31:0] hold;
        logic        chg;
        int          mids;
        int          j;
        k = ($urandom_range(3) == 0) ? gen_slot : 8'($urandom_range(255));
        gen_now += $urandom_range(20);
        t0 = gen_now;
        push_poll(k, 1'($urandom_range(1)), 1'b1, 1'b1, t0);
        case ($urandom_range(5))
            0: hold = 32'(hold_ms) - 1;
            1: hold = 32'(hold_ms);
            2: hold = 32'(hold_ms) + 1;
            3: hold = 0;
            default: hold = $urandom_range(2 * 32'(hold_ms) + 2);
        endcase
        mids = $urandom_range(3);
        for (j = 1; j <= mids; j++)
        begin
            chg = 1'($urandom_range(1));
            if (chg)
                k = 8'($urandom_range(255));
            push_poll(k, chg, 1'b0, 1'b1, t0 + hold / (mids + 1) * j);
        end
        gen_now = t0 + hold;
        push_poll(k, 1'($urandom_range(1)), 1'b1, 1'b0, gen_now);
        gen_slot = k;
    endtask

    task automatic noise_poll();
        logic [31:0] t_ms;
        t_ms = ($urandom_range(1) == 0) ? $urandom() : gen_now + $urandom_range(100);
        push_poll(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), t_ms);
    endtask

    task automatic run_phase(input int n_items, input int send_pct, input int recv_pct,
                             input bit pause_midway);
        int pick;
        @(negedge clk);
        queued_count = 0;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        while (queued_count < n_items)
        begin
            if (pause_midway && queued_count >= n_items / 2)
            begin
                // hold the sender until every result is back
                wait_idle();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 45)
                browse_run();
            else if (pick < 85)
                press_run();
            else
                noise_poll();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed polls at the reset register values
        push_poll(8'd0,   1'b0, 1'b0, 1'b0, 32'd0);
        push_poll(8'd0,   1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);  // release with no press
        push_poll(8'd255, 1'b1, 1'b0, 1'b0, 32'd100);
        push_poll(8'd9,   1'b1, 1'b0, 1'b0, 32'd200);
        push_poll(8'd42,  1'b1, 1'b0, 1'b0, 32'd300);
        push_poll(8'd42,  1'b0, 1'b0, 1'b0, 32'd3299);
        push_poll(8'd42,  1'b0, 1'b0, 1'b0, 32'd3300);       // timeout, blank
        push_poll(8'd42,  1'b0, 1'b0, 1'b0, 32'd3599);
        push_poll(8'd42,  1'b0, 1'b0, 1'b0, 32'd3600);       // blink over, restore
        push_poll(8'd100, 1'b1, 1'b0, 1'b0, 32'd4000);
        push_poll(8'd100, 1'b0, 1'b0, 1'b0, 32'd7000);
        push_poll(8'd100, 1'b0, 1'b1, 1'b1, 32'd7100);       // press during blink
        push_poll(8'd100, 1'b0, 1'b0, 1'b1, 32'd20000);      // held down, no timeout
        push_poll(8'd100, 1'b0, 1'b1, 1'b0, 32'd8099);       // one short of save
        push_poll(8'd7,   1'b1, 1'b1, 1'b1, 32'd9000);
        push_poll(8'd8,   1'b1, 1'b1, 1'b0, 32'd10000);      // exactly the save hold
        push_poll(8'd99,  1'b1, 1'b0, 1'b0, 32'hFFFF_FF00);
        push_poll(8'd99,  1'b0, 1'b0, 1'b0, 32'h0000_0AB7);  // wrapped, one short
        push_poll(8'd99,  1'b0, 1'b0, 1'b0, 32'h0000_0AB8);
        push_poll(8'd50,  1'b1, 1'b0, 1'b0, 32'h0000_0B00);  // knob turn during blink
        push_poll(8'd8,   1'b1, 1'b0, 1'b0, 32'h0000_0C00);  // back to active slot
        push_poll(8'd8,   1'b0, 1'b0, 1'b0, 32'h0001_0000);
        push_poll(8'd200, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0);
        push_poll(8'd200, 1'b0, 1'b1, 1'b0, 32'h0000_03D8);  // wrapped hold
        gen_now = 32'h0002_0000;
        gen_slot = 8'd200;
        wait_idle();

        run_phase(250, 0, 0, 1'b0);

        set_config(16'd0, 16'd0, 16'd0);
        run_phase(300, 88, 0, 1'b0);

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        gen_now = 32'hFFFF_0000;
        run_phase(300, 0, 88, 1'b0);

        set_config(16'($urandom_range(5000, 100)), 16'($urandom_range(5000, 100)),
                   16'($urandom_range(2000, 50)));
        run_phase(300, 9, 9, 1'b1);

        set_config(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
                   16'($urandom_range(40, 1)));
        run_phase(300, 0, 0, 1'b0);

        set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
        run_phase(300, 88, 0, 1'b0);

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
